### hw/rtl/quoted_printable_decoder_assert.svh
// Assertion macros shared by the quoted-printable decoder RTL.
`ifndef QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpd assertion failed");

// Next-cycle implication, checked outside reset.
`define QPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpd assertion failed");

`endif

### hw/rtl/qpd_pkg.sv
// Types and constants of the quoted-printable decoder.
package qpd_pkg;

    localparam int DATA_W      = 8;
    localparam int MAX_RESULTS = 3;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [DATA_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [DATA_W-1:0] CH_US    = 8'h5F;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_EQ     = 2'd1,
        PH_HEX    = 2'd2,
        PH_CR     = 2'd3
    } qpd_phase_t;

    // Decoded bytes of one input word; a count of zero with msg_end set is a bare end marker.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][DATA_W-1:0] data;
        logic [1:0]                         count;
        logic                               msg_end;
    } qpd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qpd_q_status_t;

endpackage

### hw/rtl/qpd_front.sv
// Front end: accepts encoded bytes, tracks the escape state and builds result entries.
module qpd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                underscore_to_space,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                message_end,
    output logic                push,
    output qpd_pkg::qpd_entry_t entry
);

    qpd_pkg::qpd_phase_t phase_reg;
    qpd_pkg::qpd_phase_t phase_next;
    logic [7:0]          held_reg;
    logic [7:0]          held_next;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

    // Returns {emits, byte} for a byte handled outside an escape.
    function automatic logic [8:0] plain_out(input logic [7:0] c, input logic u2s);
        if (c == qpd_pkg::CH_US && u2s)
        begin
            plain_out = {1'b1, qpd_pkg::CH_SPACE};
        end
        else if (c == qpd_pkg::CH_EQ)
        begin
            plain_out = 9'h000;
        end
        else
        begin
            plain_out = {1'b1, c};
        end
    endfunction

    function automatic qpd_pkg::qpd_phase_t plain_phase(input logic [7:0] c);
        plain_phase = (c == qpd_pkg::CH_EQ) ? qpd_pkg::PH_EQ : qpd_pkg::PH_NORMAL;
    endfunction

    // Next escape state.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            if (message_end)
            begin
                phase_next = qpd_pkg::PH_NORMAL;
                held_next  = 8'h00;
            end
            else
            begin
                unique case (phase_reg)
                    qpd_pkg::PH_NORMAL:
                    begin
                        phase_next = plain_phase(in_byte);
                    end
                    qpd_pkg::PH_EQ:
                    begin
                        if (in_byte == qpd_pkg::CH_LF)
                        begin
                            phase_next = qpd_pkg::PH_NORMAL;
                        end
                        else if (in_byte == qpd_pkg::CH_CR)
                        begin
                            phase_next = qpd_pkg::PH_CR;
                        end
                        else if (hex_ok(in_byte))
                        begin
                            phase_next = qpd_pkg::PH_HEX;
                            held_next  = in_byte;
                        end
                        else
                        begin
                            phase_next = plain_phase(in_byte);
                        end
                    end
                    qpd_pkg::PH_HEX:
                    begin
                        if (hex_ok(held_reg) && hex_ok(in_byte))
                        begin
                            phase_next = qpd_pkg::PH_NORMAL;
                        end
                        else
                        begin
                            phase_next = plain_phase(in_byte);
                        end
                    end
                    qpd_pkg::PH_CR:
                    begin
                        phase_next = plain_phase(in_byte);
                    end
                    default:
                    begin
                        phase_next = qpd_pkg::PH_NORMAL;
                    end
                endcase
            end
        end
    end

    // Result bytes caused by the current input word.
    always_comb
    begin
        logic [qpd_pkg::MAX_RESULTS-1:0][7:0] d_v;
        logic [1:0]                           n_v;
        logic [8:0]                           p_v;
        logic                                 esc_more;
        d_v      = '0;
        n_v      = 2'd0;
        p_v      = 9'h000;
        esc_more = (in_byte != qpd_pkg::CH_LF) && (in_byte != qpd_pkg::CH_CR);
        unique case (phase_reg)
            qpd_pkg::PH_NORMAL:
            begin
                p_v = plain_out(in_byte, underscore_to_space);
                if (p_v[8])
                begin
                    d_v[n_v] = p_v[7:0];
                    n_v      = n_v + 2'd1;
                end
            end
            qpd_pkg::PH_EQ:
            begin
                if (esc_more && !hex_ok(in_byte))
                begin
                    d_v[n_v] = qpd_pkg::CH_EQ;
                    n_v      = n_v + 2'd1;
                    p_v      = plain_out(in_byte, underscore_to_space);
                    if (p_v[8])
                    begin
                        d_v[n_v] = p_v[7:0];
                        n_v      = n_v + 2'd1;
                    end
                end
                else if (message_end && esc_more)
                begin
                    // A single hex digit pending at message end comes out literally.
                    d_v[0] = qpd_pkg::CH_EQ;
                    d_v[1] = in_byte;
                    n_v    = 2'd2;
                end
            end
            qpd_pkg::PH_HEX:
            begin
                if (hex_ok(held_reg) && hex_ok(in_byte))
                begin
                    d_v[0] = {hex_val(held_reg), hex_val(in_byte)};
                    n_v    = 2'd1;
                end
                else
                begin
                    d_v[n_v] = qpd_pkg::CH_EQ;
                    n_v      = n_v + 2'd1;
                    p_v      = plain_out(held_reg, underscore_to_space);
                    if (p_v[8])
                    begin
                        d_v[n_v] = p_v[7:0];
                        n_v      = n_v + 2'd1;
                    end
                    p_v = plain_out(in_byte, underscore_to_space);
                    if (p_v[8])
                    begin
                        d_v[n_v] = p_v[7:0];
                        n_v      = n_v + 2'd1;
                    end
                end
            end
            qpd_pkg::PH_CR:
            begin
                if (in_byte != qpd_pkg::CH_LF)
                begin
                    p_v = plain_out(in_byte, underscore_to_space);
                    if (p_v[8])
                    begin
                        d_v[n_v] = p_v[7:0];
                        n_v      = n_v + 2'd1;
                    end
                end
            end
            default:
            begin
                n_v = 2'd0;
            end
        endcase
        entry.data    = d_v;
        entry.count   = n_v;
        entry.msg_end = message_end;
        push          = accept && ((n_v != 2'd0) || message_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qpd_pkg::PH_NORMAL;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

### hw/rtl/qpd_queue.sv
// Short FIFO of result entries between the front end and the output stage.
module qpd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  qpd_pkg::qpd_entry_t    push_entry,
    input  logic                   pop,
    output qpd_pkg::qpd_entry_t    head,
    output qpd_pkg::qpd_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    qpd_pkg::qpd_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### hw/rtl/qpd_back.sv
// Back end: walks the bytes of the head entry into a registered output word.
module qpd_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qpd_pkg::qpd_entry_t    head,
    input  qpd_pkg::qpd_q_status_t status,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic [1:0] user_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic       load;
    logic       at_last;

    assign load     = !status.empty && (!valid_reg || m_tready);
    assign last_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
    assign at_last  = (idx_reg == last_idx);
    assign pop      = load && at_last;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // A bare end marker carries a zero byte.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= (head.count == 2'd0) ? 8'h00 : head.data[idx_reg];
            user_reg <= {at_last, head.count != 2'd0};
            last_reg <= at_last && head.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/quoted_printable_decoder.sv
// Quoted-printable decoder: front end, entry queue and output stage.
//
// Encoded bytes enter on the s_ stream, one word per byte, with s_tlast on the
// last byte of a message. Decoded bytes leave on the m_ stream: m_tlast marks
// the final word of a message, m_tuser[0] says a byte is present (clear on a
// bare end marker) and m_tuser[1] marks the last word caused by one input byte.
// The front end takes one byte per cycle as long as the entry queue has room;
// an input byte yields zero to three output words.
// An accepted word goes into the queue and then into the output register.
// The output stage sends one word per cycle while m_tready is high and holds
// an entry until its last word is sent; the FIFO_DEPTH-entry queue absorbs
// bursts, and s_tready drops only when it is full. When m_tready is low the
// output word holds and the queue fills behind it.
// Reset clears the escape state, the queue and the output stage, and the
// underscore-to-space register (APB byte address 0) returns to zero.
module quoted_printable_decoder
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic [1:0]                      m_tuser,   // [0] byte_present, [1] run_last
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    `include "quoted_printable_decoder_assert.svh"

    logic                   u2s_reg;
    logic                   accept;
    logic                   push;
    logic                   pop;
    qpd_pkg::qpd_entry_t    push_entry;
    qpd_pkg::qpd_entry_t    head;
    qpd_pkg::qpd_q_status_t q_status;

    // Only one register: every address decodes to it.
    assign pready = 1'b1;
    assign prdata = {{(qpd_pkg::APB_DATA_W-1){1'b0}}, u2s_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u2s_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[1:0] == 2'b00 ||
                 paddr[1:0] != 2'b00))
        begin
            u2s_reg <= pwdata[0];
        end
    end

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    qpd_front u_front
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .underscore_to_space (u2s_reg),
        .accept              (accept),
        .in_byte             (s_tdata),
        .message_end         (s_tlast),
        .push                (push),
        .entry               (push_entry)
    );

    qpd_queue #(.DEPTH(FIFO_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    qpd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .status   (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `QPD_ASSERT_IMPL(a_bare_marker_ends, m_tvalid && !m_tuser[0], m_tlast && m_tuser[1])
    `QPD_ASSERT_IMPL(a_done_is_run_last, m_tvalid && m_tlast, m_tuser[1])
    `QPD_ASSERT_NEXT(a_queue_drains, !m_tvalid && !q_status.empty, m_tvalid)

endmodule
